// ===== design/mscut_pkg.sv =====
// Package: shared constants, codes and types of the empty-space cut table.
`timescale 1ns / 1ps
package mscut_pkg;
   localparam int MaxSpaces  = 32;
   localparam int CoordBits  = 16;
   localparam int IdxBits    = $clog2(MaxSpaces);
   localparam int CntBits    = $clog2(MaxSpaces + 1);

   localparam logic [1:0] ACT_CLEAR = 2'd0;
   localparam logic [1:0] ACT_ADD   = 2'd1;
   localparam logic [1:0] ACT_CUT   = 2'd2;

   localparam logic [1:0] KIND_STATUS = 2'd0;
   localparam logic [1:0] KIND_ENTRY  = 2'd1;
   localparam logic [1:0] KIND_EMPTY  = 2'd2;

   localparam logic [1:0] ST_OK       = 2'd0;
   localparam logic [1:0] ST_ZERO     = 2'd1;
   localparam logic [1:0] ST_CONTAIN  = 2'd2;
   localparam logic [1:0] ST_FULL     = 2'd3;

   typedef logic [CoordBits-1:0] coord_type;

   typedef struct packed {
      coord_type [2:0] c;
      coord_type [2:0] s;
   } box_type;

   typedef struct packed {
      logic [1:0] action;
      box_type    b;
   } req_type;

   typedef struct packed {
      logic [1:0]          kind;
      logic [1:0]          status;
      logic [4:0]          entry_index;
      logic [5:0]          entry_count;
      box_type             b;
      logic                last;
   } rsp_type;

   typedef enum logic [3:0] {
      S_IDLE, S_SCAN_RD, S_SCAN_CHK, S_SWAP_WR, S_SUB_GEN, S_CONT_RD, S_CONT_CHK,
      S_SUB_NEXT, S_LIST_RD, S_LIST_OUT, S_DONE
   } state_type;
endpackage

// ===== design/mscut_if.sv =====
// Interfaces: valid/ready channels for requests and results.
`timescale 1ns / 1ps
interface mscut_req_if;
   logic                  valid;
   logic                  ready;
   mscut_pkg::req_type    data;
   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

interface mscut_rsp_if;
   logic                  valid;
   logic                  ready;
   mscut_pkg::rsp_type    data;
   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

// ===== design/maximal_space_cut_table.sv =====
// Top level: table of 3D empty boxes with clear, add and cut actions.
//
// One request at a time. Each stored box lives in a 32-entry memory read
// through one registered port; one stored box is checked at a time (read,
// then compare), whether for overlap with the cut block or for containment
// of a candidate box. Clear and unused action codes go straight to one
// status result. An add of a zero-size box returns status zero; otherwise
// the stored boxes are checked for containment, stopping early when a
// containing box is found, and the box is appended if none contains it.
// A cut scans the stored boxes; each overlapped box is removed by fetching
// the last entry and writing it into its slot, then goes through seven face
// steps, with a containment check and append for each face that is kept.
// After the scan the resulting list is sent out one entry per result (the
// empty marker if no entry is left), with stalls on the result side.
// The result is held in an output register; ready is low while busy.
// Invalid action codes return one status result and leave the table alone.
`timescale 1ns / 1ps
module maximal_space_cut_table (
   input  logic              clock,
   input  logic              reset,
   mscut_req_if.sink         req,
   mscut_rsp_if.source       rsp
);
   localparam int IB = mscut_pkg::IdxBits;
   localparam int CB = mscut_pkg::CntBits;
   localparam int W  = mscut_pkg::CoordBits;

   mscut_pkg::box_type   mem [mscut_pkg::MaxSpaces];
   mscut_pkg::box_type   rd_ff;
   logic                 we;
   logic [IB-1:0]        wa, ra;
   mscut_pkg::box_type   wd;

   mscut_pkg::state_type state_ff, state_in;
   logic [1:0]           act_ff;
   mscut_pkg::box_type   blk_ff;       // request box / cut block
   mscut_pkg::box_type   sp_ff;        // removed box being split
   mscut_pkg::box_type   cand_ff, cand_in;
   logic [CB-1:0]        cnt_ff, cnt_in;
   logic [CB-1:0]        idx_ff, idx_in;   // scan index
   logic [CB-1:0]        j_ff, j_in;       // containment / list index
   logic [3:0]           face_ff, face_in;
   logic [1:0]           st_ff, st_in;
   logic                 sub_ff, sub_in;   // candidate belongs to a cut
   logic                 rv_ff, rv_in;
   mscut_pkg::rsp_type   rd_rsp_ff, rsp_in;

   // Memory: one write, one registered read.
   always_ff @(posedge clock) begin
      if (we) mem[wa] <= wd;
      rd_ff <= mem[ra];
   end

   // Overlap of stored box (rd_ff) with the block.
   function automatic logic cuts_f(mscut_pkg::box_type sp, mscut_pkg::box_type b);
      logic r;
      r = 1'b1;
      for (int a = 0; a < 3; a++) begin
         if (!({1'b0, b.c[a]} < {1'b0, sp.c[a]} + {1'b0, sp.s[a]})) r = 1'b0;
         if (!({1'b0, b.c[a]} + {1'b0, b.s[a]} > {1'b0, sp.c[a]})) r = 1'b0;
      end
      return r;
   endfunction

   function automatic logic inside_f(mscut_pkg::box_type i, mscut_pkg::box_type o);
      logic r;
      r = 1'b1;
      for (int a = 0; a < 3; a++) begin
         if (i.c[a] < o.c[a]) r = 1'b0;
         if ({1'b0, i.c[a]} + {1'b0, i.s[a]} > {1'b0, o.c[a]} + {1'b0, o.s[a]})
            r = 1'b0;
      end
      return r;
   endfunction

   // Face generator: face 2a is the low side, 2a+1 the high side of axis a.
   logic                 face_ok;
   mscut_pkg::box_type   face_box;
   always_comb begin
      logic [1:0] ax;
      logic [W:0] lo, hi, blo, bhi;
      ax = face_ff[2:1];
      face_box = sp_ff;
      face_ok = 1'b0;
      lo  = {1'b0, sp_ff.c[ax]};
      hi  = lo + {1'b0, sp_ff.s[ax]};
      blo = {1'b0, blk_ff.c[ax]};
      bhi = blo + {1'b0, blk_ff.s[ax]};
      if (!face_ff[0]) begin
         face_ok = blo > lo;
         face_box.s[ax] = W'(blo - lo);
      end else begin
         face_ok = (bhi < hi) && !bhi[W];
         face_box.c[ax] = bhi[W-1:0];
         face_box.s[ax] = W'(hi - bhi);
      end
   end

   logic cand_zero;
   assign cand_zero = (cand_ff.s[0] == '0) || (cand_ff.s[1] == '0) ||
                      (cand_ff.s[2] == '0);

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         mscut_pkg::S_IDLE:
            if (req.valid) begin
               case (req.data.action)
                  mscut_pkg::ACT_ADD: state_in = mscut_pkg::S_SUB_NEXT;
                  mscut_pkg::ACT_CUT: state_in = mscut_pkg::S_SCAN_RD;
                  default:            state_in = mscut_pkg::S_DONE;
               endcase
            end
         mscut_pkg::S_SCAN_RD:
            state_in = (idx_ff < cnt_ff) ? mscut_pkg::S_SCAN_CHK : mscut_pkg::S_LIST_RD;
         mscut_pkg::S_SCAN_CHK:
            state_in = cuts_f(rd_ff, blk_ff) ? mscut_pkg::S_SWAP_WR : mscut_pkg::S_SCAN_RD;
         mscut_pkg::S_SWAP_WR:
            state_in = mscut_pkg::S_SUB_GEN;
         mscut_pkg::S_SUB_GEN:
            if (face_ff == 4'd6) state_in = mscut_pkg::S_SCAN_RD;
            else if (face_ok) state_in = mscut_pkg::S_SUB_NEXT;
         mscut_pkg::S_SUB_NEXT:
            if (cand_zero) state_in = sub_ff ? mscut_pkg::S_SUB_GEN : mscut_pkg::S_DONE;
            else state_in = mscut_pkg::S_CONT_RD;
         mscut_pkg::S_CONT_RD:
            if (j_ff < cnt_ff) state_in = mscut_pkg::S_CONT_CHK;
            else state_in = sub_ff ? mscut_pkg::S_SUB_GEN : mscut_pkg::S_DONE;
         mscut_pkg::S_CONT_CHK:
            if (inside_f(cand_ff, rd_ff))
               state_in = sub_ff ? mscut_pkg::S_SUB_GEN : mscut_pkg::S_DONE;
            else state_in = mscut_pkg::S_CONT_RD;
         mscut_pkg::S_LIST_RD:
            state_in = (rv_ff && !rsp.ready) ? mscut_pkg::S_LIST_RD : mscut_pkg::S_LIST_OUT;
         mscut_pkg::S_LIST_OUT:
            if (rv_ff && !rsp.ready) state_in = mscut_pkg::S_LIST_OUT;
            else if (cnt_ff == '0 || j_ff + CB'(1) >= cnt_ff) state_in = mscut_pkg::S_IDLE;
            else state_in = mscut_pkg::S_LIST_RD;
         mscut_pkg::S_DONE:
            if (!(rv_ff && !rsp.ready)) state_in = mscut_pkg::S_IDLE;
         default: state_in = mscut_pkg::S_IDLE;
      endcase
   end

   // Datapath and outputs.
   always_comb begin
      cnt_in = cnt_ff; idx_in = idx_ff; j_in = j_ff; face_in = face_ff;
      st_in = st_ff; sub_in = sub_ff; cand_in = cand_ff;
      rv_in = rv_ff && !rsp.ready; rsp_in = rd_rsp_ff;
      we = 1'b0; wa = cnt_ff[IB-1:0]; wd = cand_ff;
      ra = idx_ff[IB-1:0];
      req.ready = (state_ff == mscut_pkg::S_IDLE);
      case (state_ff)
         mscut_pkg::S_IDLE: begin
            idx_in = '0; j_in = '0; st_in = mscut_pkg::ST_OK;
            sub_in = 1'b0; cand_in = req.data.b;
            if (req.valid && req.data.action == mscut_pkg::ACT_CLEAR) cnt_in = '0;
         end
         mscut_pkg::S_SCAN_RD: begin
            ra = idx_ff[IB-1:0];
            j_in = '0;
         end
         mscut_pkg::S_SCAN_CHK: begin
            if (cuts_f(rd_ff, blk_ff)) begin
               // swap-remove: fetch the last entry to fill this slot
               ra = IB'(cnt_ff - CB'(1));
               cnt_in = cnt_ff - CB'(1);
            end else idx_in = idx_ff + CB'(1);
         end
         mscut_pkg::S_SWAP_WR: begin
            we = 1'b1; wa = idx_ff[IB-1:0]; wd = rd_ff;
            face_in = '0; sub_in = 1'b1;
         end
         mscut_pkg::S_SUB_GEN: begin
            if (face_ff != 4'd6) begin
               face_in = face_ff + 4'd1;
               cand_in = face_box;
               j_in = '0;
            end
         end
         mscut_pkg::S_SUB_NEXT: begin
            j_in = '0;
            if (cand_zero && !sub_ff) st_in = mscut_pkg::ST_ZERO;
         end
         mscut_pkg::S_CONT_RD: begin
            ra = j_ff[IB-1:0];
            if (j_ff >= cnt_ff) begin
               if (cnt_ff >= CB'(mscut_pkg::MaxSpaces)) st_in = mscut_pkg::ST_FULL;
               else begin
                  we = 1'b1; wa = cnt_ff[IB-1:0]; wd = cand_ff;
                  cnt_in = cnt_ff + CB'(1);
               end
            end
         end
         mscut_pkg::S_CONT_CHK: begin
            if (inside_f(cand_ff, rd_ff)) begin
               if (!sub_ff) st_in = mscut_pkg::ST_CONTAIN;
            end else j_in = j_ff + CB'(1);
         end
         mscut_pkg::S_LIST_RD: ra = j_ff[IB-1:0];
         mscut_pkg::S_LIST_OUT: begin
            ra = j_ff[IB-1:0];
            if (!(rv_ff && !rsp.ready)) begin
               rv_in = 1'b1;
               rsp_in.status = st_ff;
               rsp_in.entry_count = 6'(cnt_ff);
               rsp_in.entry_index = 5'(j_ff);
               if (cnt_ff == '0) begin
                  rsp_in.kind = mscut_pkg::KIND_EMPTY;
                  rsp_in.b = '0; rsp_in.last = 1'b1; rsp_in.entry_index = '0;
               end else begin
                  rsp_in.kind = mscut_pkg::KIND_ENTRY;
                  rsp_in.b = rd_ff;
                  rsp_in.last = (j_ff + CB'(1) == cnt_ff);
               end
               j_in = j_ff + CB'(1);
            end
         end
         mscut_pkg::S_DONE: begin
            if (!(rv_ff && !rsp.ready)) begin
               rv_in = 1'b1;
               rsp_in.kind = mscut_pkg::KIND_STATUS;
               rsp_in.status = (act_ff == mscut_pkg::ACT_ADD) ? st_ff : mscut_pkg::ST_OK;
               rsp_in.entry_index = '0;
               rsp_in.entry_count = 6'(cnt_ff);
               rsp_in.b = '0; rsp_in.last = 1'b1;
            end
         end
         default: ;
      endcase
      // A dropped cut face on a full table sets status full.
      if (state_ff == mscut_pkg::S_CONT_RD && sub_ff && j_ff >= cnt_ff &&
          cnt_ff >= CB'(mscut_pkg::MaxSpaces)) st_in = mscut_pkg::ST_FULL;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= mscut_pkg::S_IDLE;
         cnt_ff   <= '0;
         rv_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         rv_ff    <= rv_in;
      end
      idx_ff <= idx_in; j_ff <= j_in; face_ff <= face_in; st_ff <= st_in;
      sub_ff <= sub_in; cand_ff <= cand_in; rd_rsp_ff <= rsp_in;
      if (req.valid && req.ready) begin
         act_ff <= req.data.action;
         blk_ff <= req.data.b;
      end
      if (state_ff == mscut_pkg::S_SCAN_CHK) sp_ff <= rd_ff;
   end

   assign rsp.valid = rv_ff;
   assign rsp.data  = rd_rsp_ff;

   a_cnt_range: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CB'(mscut_pkg::MaxSpaces)) else $error("count overflow");
   a_idle_ready: assert property (@(posedge clock) disable iff (reset)
      req.ready |-> state_ff == mscut_pkg::S_IDLE) else $error("ready while busy");
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && !rsp.ready |=> rsp.valid && $stable(rsp.data))
      else $error("result dropped");
endmodule
